// ===== src/bik_pkg.sv =====
// bik_pkg: request/response types, fixed-point constants and the split 64x64 multiply helpers
// shared by the log2 and exp2 pipelines and the top level of binary_interaction_kij
// depends on nothing
package bik_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] prop_first;
    logic [31:0] prop_second;
  } req_t;

  typedef struct packed {
    logic [30:0] kij;
    logic        bad_input;
  } rsp_t;

  // four 32x32 partial products of a 64x64 multiply
  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } pp_t;

  localparam int          LOG_F        = 48;
  localparam int          TAYLOR_TERMS = 28;
  localparam logic [63:0] ONE62        = 64'd1 << 62;
  localparam logic [63:0] ONE48        = 64'd1 << LOG_F;
  localparam logic [63:0] LOG_BIAS62   = 64'd62 << LOG_F;
  localparam logic [127:0] DEC19       = 128'd10000000000000000000;
  localparam logic [63:0] LN2_Q62  = 64'((128'd6931471805599453094 << 62) / DEC19);
  localparam logic [63:0] PGAO_Q62 = 64'((128'd3074013086987038480 << 62) / DEC19);
  // floor(d/6) = (d * RECIP6) >> 56 for d below 2^53
  localparam logic [63:0] RECIP6   = 64'(((128'd1 << 56) + 128'd5) / 128'd6);

  function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  // low 64 bits of (a*b) >> sh
  function automatic logic [63:0] mul_join(input pp_t p, input logic [6:0] sh);
    logic [127:0] full;
    full = {p.hh, 64'd0} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {64'd0, p.ll};
    return 64'(full >> sh);
  endfunction

endpackage

// ===== src/bik_log2.sv =====
// bik_log2: pipelined log2 in Q.48, one squaring step per two stages, tag carried alongside
// depends on bik_pkg
module bik_log2 #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [63:0]      out_log,
  output logic [TAG_W-1:0] out_tag
);
  import bik_pkg::*;

  localparam int STEPS = LOG_F;

  logic             nv_q;
  logic [5:0]       n_q;
  logic [63:0]      v_q;
  logic [TAG_W-1:0] nt_q;
  logic [5:0]       lead;

  logic             vld_q [STEPS+1];
  logic [63:0]      m_q   [STEPS+1];
  logic [63:0]      r_q   [STEPS+1];
  logic [TAG_W-1:0] tag_q [STEPS+1];

  logic             vldp_q [STEPS];
  pp_t              pp_q   [STEPS];
  logic [63:0]      rp_q   [STEPS];
  logic [TAG_W-1:0] tagp_q [STEPS];

  // leading one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (in_val[i]) lead = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) nv_q <= 1'b0;
    else if (en) nv_q <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q  <= lead;
      v_q  <= in_val;
      nt_q <= in_tag;
    end
  end

  // mantissa to Q1.62
  always_ff @(posedge clk) begin
    if (rst) vld_q[0] <= 1'b0;
    else if (en) vld_q[0] <= nv_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0]   <= (n_q == 6'd63) ? (v_q >> 1) : (v_q << (6'd62 - n_q));
      r_q[0]   <= {10'd0, n_q, 48'd0};
      tag_q[0] <= nt_q;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_it
    logic [63:0] sq;

    always_ff @(posedge clk) begin
      if (rst) vldp_q[k] <= 1'b0;
      else if (en) vldp_q[k] <= vld_q[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pp_q[k]   <= mul_parts(m_q[k], m_q[k]);
        rp_q[k]   <= r_q[k];
        tagp_q[k] <= tag_q[k];
      end
    end

    assign sq = mul_join(pp_q[k], 7'd62);

    always_ff @(posedge clk) begin
      if (rst) vld_q[k+1] <= 1'b0;
      else if (en) vld_q[k+1] <= vldp_q[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[k+1]   <= sq[63] ? (sq >> 1) : sq;
        r_q[k+1]   <= rp_q[k] | (sq[63] ? (64'd1 << (STEPS - 1 - k)) : 64'd0);
        tag_q[k+1] <= tagp_q[k];
      end
    end
  end

  assign out_valid = vld_q[STEPS];
  assign out_log   = r_q[STEPS];
  assign out_tag   = tag_q[STEPS];

endmodule

// ===== src/bik_exp2.sv =====
// bik_exp2: pipelined 2^-e in Q1.62 from a Taylor series of exp(-y), four stages per term
// depends on bik_pkg
module bik_exp2 #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      in_e,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [63:0]      out_pow,
  output logic [TAG_W-1:0] out_tag
);
  import bik_pkg::*;

  localparam int NT = TAYLOR_TERMS;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [5:0]       sh;
    logic             big;
    logic [63:0]      y;
    logic [63:0]      sum;
  } side_t;

  logic        v0_q;
  pp_t         pp0_q;
  side_t       sd0_q;

  logic        vq    [NT+1];
  logic [63:0] term_q[NT+1];
  side_t       sd_q  [NT+1];

  logic        va_q [NT];
  pp_t         ppa_q[NT];
  side_t       sda_q[NT];
  logic        vb_q [NT];
  logic [63:0] t1_q [NT];
  side_t       sdb_q[NT];
  logic        vc_q [NT];
  pp_t         ppc_q[NT];
  side_t       sdc_q[NT];

  logic        vo_q;
  logic [63:0] pow_q;
  logic [TAG_W-1:0] to_q;

  // y = frac(e) * ln2
  always_ff @(posedge clk) begin
    if (rst) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_q     <= mul_parts({16'd0, in_e[47:0]}, LN2_Q62);
      sd0_q.tag <= in_tag;
      sd0_q.sh  <= in_e[53:48];
      sd0_q.big <= (in_e[63:48] >= 16'd63);
      sd0_q.y   <= '0;
      sd0_q.sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vq[0] <= 1'b0;
    else if (en) vq[0] <= v0_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_q[0]    <= ONE62;
      sd_q[0].tag  <= sd0_q.tag;
      sd_q[0].sh   <= sd0_q.sh;
      sd_q[0].big  <= sd0_q.big;
      sd_q[0].y    <= mul_join(pp0_q, 7'd48);
      sd_q[0].sum  <= ONE62;
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int K = j + 1;
    localparam int L = $clog2(K);
    localparam logic [63:0] RECIP =
      64'(((128'd1 << (62 + L)) + 128'(K - 1)) / 128'(K));
    logic [63:0] tn;

    always_ff @(posedge clk) begin
      if (rst) begin
        va_q[j] <= 1'b0;
        vb_q[j] <= 1'b0;
        vc_q[j] <= 1'b0;
        vq[j+1] <= 1'b0;
      end else if (en) begin
        va_q[j] <= vq[j];
        vb_q[j] <= va_q[j];
        vc_q[j] <= vb_q[j];
        vq[j+1] <= vc_q[j];
      end
    end

    assign tn = mul_join(ppc_q[j], 7'(62 + L));

    always_ff @(posedge clk) begin
      if (en) begin
        ppa_q[j] <= mul_parts(term_q[j], sd_q[j].y);
        sda_q[j] <= sd_q[j];
        t1_q[j]  <= mul_join(ppa_q[j], 7'd62);
        sdb_q[j] <= sda_q[j];
        ppc_q[j] <= mul_parts(t1_q[j], RECIP);
        sdc_q[j] <= sdb_q[j];
        term_q[j+1]     <= tn;
        sd_q[j+1].tag   <= sdc_q[j].tag;
        sd_q[j+1].sh    <= sdc_q[j].sh;
        sd_q[j+1].big   <= sdc_q[j].big;
        sd_q[j+1].y     <= sdc_q[j].y;
        sd_q[j+1].sum   <= (K % 2 == 1) ? (sdc_q[j].sum - tn) : (sdc_q[j].sum + tn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vo_q <= 1'b0;
    else if (en) vo_q <= vq[NT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pow_q <= sd_q[NT].big ? 64'd0 : (sd_q[NT].sum >> sd_q[NT].sh);
      to_q  <= sd_q[NT].tag;
    end
  end

  assign out_valid = vo_q;
  assign out_pow   = pow_q;
  assign out_tag   = to_q;

endmodule

// ===== src/binary_interaction_kij.sv =====
// binary_interaction_kij: Chueh-Prausnitz / Gao binary interaction parameter, deep pipeline
// depends on bik_pkg, bik_log2, bik_exp2
//
//  channel | valid     | stall     | payload            | role
//  request | req_valid | req_stall | req (bik_pkg::req_t) | property pair and mode in
//  result  | rsp_valid | rsp_stall | rsp (bik_pkg::rsp_t) | kij in Q1.30 and zero flag out
//
// one request per cycle while req_stall is low
// the result path runs through two 48-step log2 pipelines in series (98 stages each) and two
// 28-term exp2 pipelines (115 stages each)
// rst is synchronous and clears every valid bit and the output queue
// the whole pipeline advances together; it freezes only when the 2-entry output queue is full,
// so a request is still taken while one result waits on a stalled rsp
module binary_interaction_kij (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bik_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bik_pkg::rsp_t  rsp
);
  import bik_pkg::*;

  // side information that rides along the log/exp pipelines
  typedef struct packed {
    logic        func;
    logic        bad;
    logic [63:0] s;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  logic en;

  // input register, zero properties replaced by one so the logs stay defined
  logic        v0_q, func0_q, bad0_q;
  logic [31:0] a0_q, b0_q;

  always_ff @(posedge clk) begin
    if (rst) v0_q <= 1'b0;
    else if (en) v0_q <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func0_q <= req.func;
      bad0_q  <= (req.prop_first == '0) || (req.prop_second == '0);
      a0_q    <= (req.prop_first == '0) ? 32'd1 : req.prop_first;
      b0_q    <= (req.prop_second == '0) ? 32'd1 : req.prop_second;
    end
  end

  // log2 of both properties side by side
  logic        va, vb;
  logic [63:0] la, lb;
  logic [1:0]  ta, tb;

  bik_log2 #(.TAG_W(2)) u_log_a (
    .clk, .rst, .en,
    .in_valid(v0_q), .in_val({32'd0, a0_q}), .in_tag({func0_q, bad0_q}),
    .out_valid(va), .out_log(la), .out_tag(ta)
  );

  bik_log2 #(.TAG_W(2)) u_log_b (
    .clk, .rst, .en,
    .in_valid(v0_q), .in_val({32'd0, b0_q}), .in_tag({func0_q, bad0_q}),
    .out_valid(vb), .out_log(lb), .out_tag(tb)
  );

  // d = |la - lb|
  logic        v1_q, func1_q, bad1_q;
  logic [63:0] d1_q;

  always_ff @(posedge clk) begin
    if (rst) v1_q <= 1'b0;
    else if (en) v1_q <= va & vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1_q <= ta[1];
      bad1_q  <= tb[0];
      d1_q    <= (la >= lb) ? (la - lb) : (lb - la);
    end
  end

  // s = d/2 for gao, d/6 for chueh-prausnitz (reciprocal multiply, exact below 2^53)
  logic        v2_q, func2_q, bad2_q;
  logic [63:0] d2_q;
  pp_t         pp6_q;

  always_ff @(posedge clk) begin
    if (rst) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2_q <= func1_q;
      bad2_q  <= bad1_q;
      d2_q    <= d1_q;
      pp6_q   <= mul_parts(d1_q, RECIP6);
    end
  end

  logic v3_q;
  ctx_t c3_q;

  always_ff @(posedge clk) begin
    if (rst) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_q.func <= func2_q;
      c3_q.bad  <= bad2_q;
      c3_q.s    <= func2_q ? (d2_q >> 1) : mul_join(pp6_q, 7'd56);
    end
  end

  // w = 2^-2s
  logic             vw;
  logic [63:0]      w;
  logic [CTX_W-1:0] cw;

  bik_exp2 #(.TAG_W(CTX_W)) u_exp_w (
    .clk, .rst, .en,
    .in_valid(v3_q), .in_e(c3_q.s << 1), .in_tag(c3_q),
    .out_valid(vw), .out_pow(w), .out_tag(cw)
  );

  // log2(1 + 2^-2s), still biased by 62
  logic             vl;
  logic [63:0]      lg;
  logic [CTX_W-1:0] cl;
  ctx_t             cl_s;

  bik_log2 #(.TAG_W(CTX_W)) u_log_w (
    .clk, .rst, .en,
    .in_valid(vw), .in_val(ONE62 + w), .in_tag(cw),
    .out_valid(vl), .out_log(lg), .out_tag(cl)
  );

  assign cl_s = ctx_t'(cl);

  // -log2 t = s + log2(1 + 2^-2s) - 1, clamped at zero
  logic        v4_q, func4_q, bad4_q;
  logic [63:0] e4_q;

  always_ff @(posedge clk) begin
    if (rst) v4_q <= 1'b0;
    else if (en) v4_q <= vl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func4_q <= cl_s.func;
      bad4_q  <= cl_s.bad;
      e4_q    <= cl_s.s + lg - LOG_BIAS62;
    end
  end

  logic        v5_q, func5_q, bad5_q;
  logic [63:0] e5_q;

  always_ff @(posedge clk) begin
    if (rst) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func5_q <= func4_q;
      bad5_q  <= bad4_q;
      e5_q    <= (e4_q > ONE48) ? (e4_q - ONE48) : 64'd0;
    end
  end

  // exponent times p: 3 for chueh-prausnitz, 0.3074 for gao
  logic        v6_q, func6_q, bad6_q;
  logic [63:0] e3_q;
  pp_t         ppg_q;

  always_ff @(posedge clk) begin
    if (rst) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func6_q <= func5_q;
      bad6_q  <= bad5_q;
      e3_q    <= e5_q + (e5_q << 1);
      ppg_q   <= mul_parts(e5_q, PGAO_Q62);
    end
  end

  logic        v7_q, bad7_q;
  logic [63:0] ep7_q;

  always_ff @(posedge clk) begin
    if (rst) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad7_q <= bad6_q;
      ep7_q  <= func6_q ? mul_join(ppg_q, 7'd62) : e3_q;
    end
  end

  // t^p = 2^-ep
  logic        vt;
  logic [63:0] tp;
  logic        bt;

  bik_exp2 #(.TAG_W(1)) u_exp_t (
    .clk, .rst, .en,
    .in_valid(v7_q), .in_e(ep7_q), .in_tag(bad7_q),
    .out_valid(vt), .out_pow(tp), .out_tag(bt)
  );

  // kij = 1 - t^p, rounded to Q1.30
  logic        v8_q;
  rsp_t        r8_q;
  logic [63:0] tpc, diff;

  assign tpc  = (tp > ONE62) ? ONE62 : tp;
  assign diff = (ONE62 - tpc) + (64'd1 << 31);

  always_ff @(posedge clk) begin
    if (rst) v8_q <= 1'b0;
    else if (en) v8_q <= vt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r8_q.kij       <= bt ? 31'd0 : diff[62:32];
      r8_q.bad_input <= bt;
    end
  end

  // 2-entry output queue, parts the result stall from the pipeline enable
  rsp_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign en        = ~cnt_q[1];
  assign req_stall = ~en;
  assign push      = en & v8_q;
  assign rsp_valid = (cnt_q != 2'd0);
  assign pop       = rsp_valid & ~rsp_stall;
  assign rsp       = q_mem[rd_q];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_q] <= r8_q;
  end

endmodule

// ===== src/bik_check.sv =====
// bik_check: port-level checks of binary_interaction_kij, bound to the top level
// depends on bik_pkg and binary_interaction_kij
module bik_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input bik_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bik_pkg::rsp_t rsp
);
  import bik_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_input |-> rsp.kij == 31'd0)
    else $error("kij not zero on bad input");

  a_kij_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.kij <= 31'h4000_0000)
    else $error("kij above one");

endmodule

bind binary_interaction_kij bik_check u_bik_check (.*);

// ===== test/testbench.sv =====
// testbench for binary_interaction_kij: random and directed property pairs, checked against
// a bit-exact fixed-point predictor of kij (log2 / exp2 in 64-bit integer arithmetic)
// depends on bik_pkg and the binary_interaction_kij rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bik_pkg::*;

  localparam int LAT = 436;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [63:0] ONE_Q48 = 64'd1 << 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  binary_interaction_kij dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_t pending_reqs[$];
  rsp_t expected_kij[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   sending_done = 1'b0;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // (a*b) >> sh, low 64 bits
  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] full;
    full = 128'(a) * 128'(b);
    return 64'(full >> sh);
  endfunction

  // floor(num / 10^19 * 2^62)
  function automatic logic [63:0] frac_q62(logic [127:0] num);
    return 64'((num << 62) / 128'd10000000000000000000);
  endfunction

  // log2 in Q.48, bit-serial squaring of a Q1.62 mantissa
  function automatic logic [63:0] log2_q48(logic [63:0] v);
    int n;
    logic [63:0] m, r;
    n = 63;
    while (n > 0 && v[n] == 1'b0) n--;
    m = (n == 63) ? (v >> 1) : (v << (62 - n));
    r = 64'(n) << 48;
    for (int k = 1; k <= 48; k++) begin
      m = mulsh(m, m, 62);
      if (m[63]) begin
        m = m >> 1;
        r[48 - k] = 1'b1;
      end
    end
    return r;
  endfunction

  // 2^-e in Q1.62, e in Q.48, taylor series of exp(-y)
  function automatic logic [63:0] pow2_neg(logic [63:0] e, logic [63:0] ln2);
    logic [63:0] n, f, y, term, sum;
    n = e >> 48;
    f = e & (ONE_Q48 - 1);
    if (n >= 63) return 64'd0;
    y = mulsh(f, ln2, 48);
    term = ONE62;
    sum = ONE62;
    for (int k = 1; k <= 28; k++) begin
      term = mulsh(term, y, 62) / 64'(k);
      if (k & 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum >> n;
  endfunction

  function automatic rsp_t predict_kij(req_t r);
    rsp_t o;
    logic [63:0] ln2, pgao, la, lb, d, s, w, lg, e, ep, tp, k;
    o = '0;
    // zero property: error flag, kij 0
    if (r.prop_first == 0 || r.prop_second == 0) begin
      o.bad_input = 1'b1;
      return o;
    end
    ln2 = frac_q62(128'd6931471805599453094);
    pgao = frac_q62(128'd3074013086987038480);
    la = log2_q48(64'(r.prop_first));
    lb = log2_q48(64'(r.prop_second));
    d = (la >= lb) ? la - lb : lb - la;
    s = r.func ? d / 2 : d / 6;
    // -log2 t = s + log2(1 + 2^-2s) - 1
    w = pow2_neg(2 * s, ln2);
    lg = log2_q48(ONE62 + w) - (64'd62 << 48);
    e = s + lg;
    // rounding below zero clamps to 0
    e = (e > ONE_Q48) ? e - ONE_Q48 : 64'd0;
    ep = r.func ? mulsh(e, pgao, 62) : 3 * e;
    tp = pow2_neg(ep, ln2);
    if (tp > ONE62) tp = ONE62;
    k = ((ONE62 - tp) + (64'd1 << 31)) >> 32;
    if (k > (64'd1 << 30)) k = 64'd1 << 30;
    o.kij = k[30:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(int f, logic [31:0] a, logic [31:0] b);
    req_t r;
    r.func = f[0];
    r.prop_first = a;
    r.prop_second = b;
    return r;
  endfunction

  // property spread over many magnitudes by a random right shift
  function automatic logic [31:0] rand_prop();
    int sh;
    sh = $urandom_range(0, 31);
    return $urandom() >> sh;
  endfunction

  initial begin
    logic [31:0] base;
    // directed: zero properties, equal properties, extremes, both modes
    for (int f = 0; f < 2; f++) begin
      pending_reqs.push_back(make_req(f, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(f, 32'd0, 32'h0001_0000));
      pending_reqs.push_back(make_req(f, 32'hFFFF_FFFF, 32'd0));
      pending_reqs.push_back(make_req(f, 32'd1, 32'd1));
      pending_reqs.push_back(make_req(f, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(f, 32'h0001_0000, 32'h0001_0000));
      // widest ratio, tiny power and saturation
      pending_reqs.push_back(make_req(f, 32'd1, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(f, 32'hFFFF_FFFF, 32'd1));
      pending_reqs.push_back(make_req(f, 32'h0001_0000, 32'h0001_0001));
      pending_reqs.push_back(make_req(f, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_reqs.push_back(make_req(f, 32'd2, 32'd1));
      pending_reqs.push_back(make_req(f, 32'h5555_5555, 32'hAAAA_AAAA));
    end
    for (int i = 0; i < 700; i++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(make_req($urandom(), $urandom(), $urandom()));
        1: pending_reqs.push_back(make_req($urandom(), rand_prop(), 32'd0));
        2: begin
          base = $urandom();
          pending_reqs.push_back(make_req($urandom(), base, base));
        end
        3, 4, 5: begin
          base = $urandom() | 32'h100;
          pending_reqs.push_back(make_req($urandom(), base,
                                          base + $urandom_range(0, 255) - 128));
        end
        default: pending_reqs.push_back(make_req($urandom(), rand_prop(), rand_prop()));
      endcase
    end
  end

  // reset
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  int req_gap = 0;
  int sent_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_kij.push_back(predict_kij(req));
        sent_count <= sent_count + 1;
      end
      // valid and payload hold while stalled
      if (!req_valid || !req_stall) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          // bursts with no gap during the first two hundred requests
          req_gap <= (sent_count < 200) ? 0 : $urandom_range(0, 3);
        end else begin
          req_valid <= 1'b0;
          sending_done <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver stalls
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rsp_count = 0;
  rsp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_count <= rsp_count + 1;
        if (expected_kij.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kij=%0d bad_input=%0b", rsp.kij, rsp.bad_input);
        end else begin
          want = expected_kij.pop_front();
          if (rsp.kij !== want.kij || rsp.bad_input !== want.bad_input) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kij exp=%0d got=%0d, bad_input exp=%0b got=%0b",
                       want.kij, rsp.kij, want.bad_input, rsp.bad_input);
          end
        end
      end
      // long hold-off once, while requests keep coming, to fill the pipeline
      if (!hold_done && rsp_count == 20) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        // per result random stall, none in early stretch
        stall_left = (rsp_count < 100) ? 0 : $urandom_range(0, 3);
        rsp_stall <= (stall_left > 0);
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= (stall_left > 0);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog and end of run
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (!rst);
    wait (sending_done && expected_kij.size() == 0);
    // a late extra result would show up here
    repeat (LAT + 50) @(posedge clk);
    if (mismatches == 0 && expected_kij.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
